### rtl/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types, character codes and helpers for the INI stream tokenizer.
// ----------------------------------------------------------------------------
package ist_pkg;

  // Held whitespace buffer
  localparam int HeldDepth = 16;
  localparam int CntW      = $clog2(HeldDepth + 1);
  localparam int IdxW      = (HeldDepth > 1) ? $clog2(HeldDepth) : 1;

  localparam logic [7:0] BreakReset = 8'd59;

  // Character codes
  localparam logic [7:0] ChLBrack    = 8'h5B;
  localparam logic [7:0] ChRBrack    = 8'h5D;
  localparam logic [7:0] ChEquals    = 8'h3D;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChSemi      = 8'h3B;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChVt        = 8'h0B;
  localparam logic [7:0] ChFf        = 8'h0C;
  localparam logic [7:0] ChCr        = 8'h0D;

  typedef enum logic [2:0] {
    M_INIT    = 3'd0,
    M_COMMENT = 3'd1,
    M_SECTION = 3'd2,
    M_KEY     = 3'd3,
    M_VALUE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SECTION = 2'd0,
    KIND_KEY     = 2'd1,
    KIND_VALUE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MARK_CHAR    = 2'd0,
    MARK_DONE    = 2'd1,
    MARK_DISCARD = 2'd2
  } mark_t;

  // What an accepted byte asks of the output side
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ONE   = 2'd1,
    ACT_FLUSH = 2'd2
  } act_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FLUSH = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic load_direct;
    logic load_held;
    logic load_pend;
  } ist_cmd_t;

  typedef struct packed {
    act_t act;
    logic flush_end;
    logic slot_free;
  } ist_sts_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) ||
           (c == ChVt) || (c == ChFf) || (c == ChCr);
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == ChLf) || (c == ChCr) || (c == ChVt);
  endfunction

endpackage

### rtl/ist_ctrl.sv
// ----------------------------------------------------------------------------
// ist_ctrl
// Sequencer: takes bytes, and walks the held whitespace out before a character.
// ----------------------------------------------------------------------------
module ist_ctrl import ist_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ist_sts_t sts,
  output ist_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.slot_free && (sts.act == ACT_FLUSH)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts.slot_free && sts.flush_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready         = sts.slot_free;
        cmd.take         = in_valid && sts.slot_free;
        cmd.load_direct  = cmd.take && (sts.act == ACT_ONE);
      end
      ST_FLUSH: begin
        cmd.load_held = sts.slot_free && !sts.flush_end;
        cmd.load_pend = sts.slot_free && sts.flush_end;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/ist_dp.sv
// ----------------------------------------------------------------------------
// ist_dp
// Parser state, byte decode, held whitespace buffer and output register.
// ----------------------------------------------------------------------------
module ist_dp import ist_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic [7:0] in_byte,
  input  ist_cmd_t   cmd,
  output ist_sts_t   sts,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic [1:0] token_kind,
  output logic [1:0] mark,
  output logic       space_overflow,
  output logic       last
);

  // Parser state
  logic [7:0]      brk_r;
  mode_t           mode_r, mode_nxt, mode_n;
  logic            esc_r, esc_nxt;
  logic            quo_r, quo_nxt;
  logic            begun_r;
  logic [CntW-1:0] cnt_r;
  logic            drop_r;
  logic [7:0]      held_r [HeldDepth];

  // Pending character behind a flush
  logic [7:0]      pend_ch_r;
  kind_t           pend_kind_r;
  logic            pend_ovf_r;
  logic [CntW-1:0] pend_cnt_r;
  logic [CntW-1:0] idx_r;

  // Output register
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r;
  kind_t           out_kind_r;
  mark_t           out_mark_r;
  logic            out_ovf_r;
  logic            out_last_r;

  // Decode results
  logic  do_emit, do_fin, do_hold, quo_t;
  logic [7:0] e_ch;
  kind_t e_kind, f_kind;
  mark_t f_mark;
  logic  ovf_char;

  always_comb begin
    case (mode_r)
      M_COMMENT, M_SECTION, M_KEY, M_VALUE: mode_n = mode_r;
      default:                              mode_n = M_INIT;
    endcase
  end

  always_comb begin
    do_emit  = 1'b0;
    do_fin   = 1'b0;
    do_hold  = 1'b0;
    e_ch     = in_byte;
    e_kind   = KIND_KEY;
    f_kind   = KIND_KEY;
    f_mark   = MARK_DONE;
    mode_nxt = mode_n;
    esc_nxt  = esc_r;
    quo_nxt  = quo_r;
    quo_t    = quo_r;
    if (esc_r) begin
      // Escaped byte: literal everywhere, ignored in comments
      esc_nxt = 1'b0;
      case (mode_n)
        M_INIT: begin
          mode_nxt = M_KEY;
          do_emit  = 1'b1;
        end
        M_SECTION: begin
          do_emit = 1'b1;
          e_kind  = KIND_SECTION;
        end
        M_KEY:   do_emit = 1'b1;
        M_VALUE: begin
          do_emit = 1'b1;
          e_kind  = KIND_VALUE;
        end
        default: do_emit = 1'b0;
      endcase
    end else if (in_byte == ChBackslash) begin
      esc_nxt = 1'b1;
    end else begin
      case (mode_n)
        M_INIT: begin
          if (in_byte == ChLBrack) begin
            mode_nxt = M_SECTION;
          end else if (in_byte == ChSemi) begin
            mode_nxt = M_COMMENT;
          end else if (!is_ws(in_byte)) begin
            mode_nxt = M_KEY;
            do_emit  = 1'b1;
            e_ch     = (in_byte == ChDot) ? ChSlash : in_byte;
          end
        end
        M_COMMENT: begin
          if (is_eol(in_byte)) mode_nxt = M_INIT;
        end
        M_SECTION: begin
          e_kind = KIND_SECTION;
          f_kind = KIND_SECTION;
          if (in_byte == ChRBrack) begin
            do_fin   = 1'b1;
            mode_nxt = M_INIT;
          end else if (is_ws(in_byte)) begin
            do_hold = 1'b1;
          end else begin
            do_emit = 1'b1;
          end
        end
        M_KEY: begin
          if (in_byte == ChEquals) begin
            do_fin   = 1'b1;
            mode_nxt = M_VALUE;
            quo_nxt  = 1'b0;
          end else if (is_eol(in_byte)) begin
            do_fin   = 1'b1;
            f_mark   = MARK_DISCARD;
            mode_nxt = M_INIT;
          end else if (in_byte == ChSemi) begin
            do_fin   = 1'b1;
            f_mark   = MARK_DISCARD;
            mode_nxt = M_COMMENT;
          end else if (in_byte == ChDot) begin
            do_emit = 1'b1;
            e_ch    = ChSlash;
          end else if (is_ws(in_byte)) begin
            do_hold = 1'b1;
          end else begin
            do_emit = 1'b1;
          end
        end
        M_VALUE: begin
          e_kind  = KIND_VALUE;
          f_kind  = KIND_VALUE;
          quo_t   = quo_r ^ (in_byte == ChQuote);
          quo_nxt = quo_t;
          if (is_eol(in_byte) ||
              (!quo_t && ((in_byte == ChSemi) || (in_byte == brk_r)))) begin
            do_fin   = 1'b1;
            mode_nxt = ((in_byte != brk_r) && (in_byte == ChSemi)) ? M_COMMENT : M_INIT;
          end else if (is_ws(in_byte)) begin
            do_hold = 1'b1;
          end else begin
            do_emit = 1'b1;
          end
        end
        default: mode_nxt = M_INIT;
      endcase
    end
  end

  assign ovf_char = begun_r && drop_r;

  always_comb begin
    sts.act = ACT_NONE;
    if (do_fin) begin
      sts.act = ACT_ONE;
    end else if (do_emit) begin
      sts.act = (begun_r && (cnt_r != '0)) ? ACT_FLUSH : ACT_ONE;
    end
    sts.flush_end = (idx_r == pend_cnt_r);
    sts.slot_free = !out_valid_r || out_ready;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_r   <= BreakReset;
      mode_r  <= M_INIT;
      esc_r   <= 1'b0;
      quo_r   <= 1'b0;
      begun_r <= 1'b0;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
    end else begin
      if (cfg_we) brk_r <= cfg_wdata;
      if (cmd.take) begin
        mode_r <= mode_nxt;
        esc_r  <= esc_nxt;
        quo_r  <= quo_nxt;
        if (do_emit) begin
          begun_r <= 1'b1;
          cnt_r   <= '0;
          drop_r  <= 1'b0;
        end else if (do_fin) begin
          begun_r <= 1'b0;
          cnt_r   <= '0;
          drop_r  <= 1'b0;
        end else if (do_hold && begun_r) begin
          if (cnt_r < CntW'(HeldDepth)) begin
            cnt_r <= cnt_r + CntW'(1);
          end else begin
            drop_r <= 1'b1;
          end
        end
      end
    end
  end

  // Held whitespace store and flush bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.take && do_hold && begun_r && (cnt_r < CntW'(HeldDepth))) begin
      held_r[cnt_r[IdxW-1:0]] <= in_byte;
    end
    if (cmd.take && do_emit) begin
      pend_ch_r   <= e_ch;
      pend_kind_r <= e_kind;
      pend_ovf_r  <= ovf_char;
      pend_cnt_r  <= cnt_r;
      idx_r       <= '0;
    end else if (cmd.load_held) begin
      idx_r <= idx_r + CntW'(1);
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load_direct || cmd.load_held || cmd.load_pend) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      out_last_r <= 1'b1;
      if (do_fin) begin
        out_char_r <= '0;
        out_kind_r <= f_kind;
        out_mark_r <= f_mark;
        out_ovf_r  <= 1'b0;
      end else begin
        out_char_r <= e_ch;
        out_kind_r <= e_kind;
        out_mark_r <= MARK_CHAR;
        out_ovf_r  <= ovf_char;
      end
    end else if (cmd.load_held) begin
      out_char_r <= held_r[idx_r[IdxW-1:0]];
      out_kind_r <= pend_kind_r;
      out_mark_r <= MARK_CHAR;
      out_ovf_r  <= pend_ovf_r;
      out_last_r <= 1'b0;
    end else if (cmd.load_pend) begin
      out_char_r <= pend_ch_r;
      out_kind_r <= pend_kind_r;
      out_mark_r <= MARK_CHAR;
      out_ovf_r  <= pend_ovf_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign token_kind     = out_kind_r;
  assign mark           = out_mark_r;
  assign space_overflow = out_ovf_r;
  assign last           = out_last_r;

endmodule

### rtl/ini_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// ini_stream_tokenizer
// Streaming INI tokenizer: one text byte in, tagged token beats out.
// ----------------------------------------------------------------------------
// One text byte enters per input beat and yields zero or more result beats:
// characters of section names, keys and values, each tagged with its kind,
// plus a completion or discard mark at the end of a token. Bytes that give
// no result or a single result are taken one per cycle as long as the result
// side keeps draining the single output register. A byte that follows held
// inner whitespace of a token first walks that whitespace out of the
// 16-entry hold buffer, one beat per cycle while the result side drains;
// the input is not ready until that byte itself has been loaded.
// The break character register may be written at any time the block is idle;
// it resets to a semicolon. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module ini_stream_tokenizer import ist_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration: break_char
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  // Text in
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  // Tokens out
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [4:0] out_tuser,  // [1:0] token_kind, [3:2] mark, [4] space_overflow
  output logic       out_tlast   // last beat caused by the input byte
);

  ist_cmd_t   cmd;
  ist_sts_t   sts;
  logic [1:0] kind_w;
  logic [1:0] mark_w;
  logic       ovf_w;

  // Sequencer: hold input while a flush is under way
  ist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Parser, hold buffer and output register
  ist_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_byte        (in_tdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_char       (out_tdata),
    .token_kind     (kind_w),
    .mark           (mark_w),
    .space_overflow (ovf_w),
    .last           (out_tlast)
  );

  // Pack the tags, kind in the lowest bits
  assign out_tuser = {ovf_w, mark_w, kind_w};

endmodule

### rtl/ist_chk.sv
// ----------------------------------------------------------------------------
// ist_chk
// Port-level checks for the INI stream tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module ist_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_we,
  input logic [7:0] cfg_wdata,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [4:0] out_tuser,
  input logic       out_tlast
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // A mark beat carries no character, no overflow and closes the byte
  a_mark_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[3:2] != 2'd0) |->
      (out_tdata == 8'd0) && !out_tuser[4] && out_tlast)
    else $error("malformed mark beat");

  // Kind and mark stay within their codes
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1:0] != 2'd3) && (out_tuser[3:2] != 2'd3))
    else $error("unused kind or mark code");

  // Input is taken only when the output register can make room
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready)
    else $error("input ready while output blocked");

endmodule

bind ini_stream_tokenizer ist_chk u_ist_chk (.*);

### sim/tb_ini_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_ini_stream_tokenizer
// Self-checking bench for the streaming INI tokenizer.
// ----------------------------------------------------------------------------
// Text bytes go in one beat at a time: a short directed run over the corner
// cases of the syntax, then random lines built from sections, key/value pairs,
// comments, abandoned keys and raw noise. A token tracker models the parser
// byte by byte and queues the token beats each byte should produce; every beat
// leaving the block is matched against the oldest queued one. The break
// character is changed between phases, and the phases vary sender gaps,
// receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ini_stream_tokenizer;
  import ist_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldOffCycles = 200;
  localparam int PhaseBytes    = 30;

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
    mark_t      mark;
    logic       ovf;
    logic       last;
  } token_beat_t;

  // Token tracker: parser state mirror plus the queue of beats still owed
  class token_tracker;
    logic [7:0]  break_char;
    mode_t       mode;
    bit          escaped;
    bit          quoted;
    bit          begun;
    bit          dropped;
    logic [7:0]  held[HeldDepth];
    int          held_n;
    token_beat_t due_beats[$];
    int          faults;

    function new();
      break_char = BreakReset;
      mode       = M_INIT;
      escaped    = 1'b0;
      quoted     = 1'b0;
      begun      = 1'b0;
      dropped    = 1'b0;
      held_n     = 0;
      faults     = 0;
    endfunction

    function bit blank(logic [7:0] c);
      return c inside {ChSpace, ChTab, ChLf, ChVt, ChFf, ChCr};
    endfunction

    function bit line_end(logic [7:0] c);
      return c inside {ChLf, ChCr, ChVt};
    endfunction

    // Flush held whitespace ahead of the character once the token has begun
    function void emit_token_char(logic [7:0] c, kind_t k);
      logic o;
      o = dropped;
      if (begun) begin
        for (int i = 0; i < held_n; i++)
          due_beats.push_back('{held[i], k, MARK_CHAR, o, 1'b0});
        due_beats.push_back('{c, k, MARK_CHAR, o, 1'b0});
      end else begin
        due_beats.push_back('{c, k, MARK_CHAR, 1'b0, 1'b0});
      end
      begun   = 1'b1;
      held_n  = 0;
      dropped = 1'b0;
    endfunction

    function void finish_token(kind_t k, mark_t m);
      due_beats.push_back('{8'h00, k, m, 1'b0, 1'b0});
      begun   = 1'b0;
      held_n  = 0;
      dropped = 1'b0;
    endfunction

    function void body_char(logic [7:0] c, kind_t k);
      if (!blank(c)) begin
        emit_token_char(c, k);
      end else if (begun) begin
        if (held_n < HeldDepth) begin
          held[held_n] = c;
          held_n++;
        end else begin
          dropped = 1'b1;
        end
      end
    endfunction

    // Note one accepted text byte and queue the beats it causes
    function void take_byte(logic [7:0] b);
      mode_t m;
      int    first;
      m     = mode;
      first = due_beats.size();
      if (escaped) begin
        escaped = 1'b0;
        case (m)
          M_INIT: begin
            m = M_KEY;
            emit_token_char(b, KIND_KEY);
          end
          M_SECTION: emit_token_char(b, KIND_SECTION);
          M_KEY:     emit_token_char(b, KIND_KEY);
          M_VALUE:   emit_token_char(b, KIND_VALUE);
          default:   ;
        endcase
      end else if (b == ChBackslash) begin
        escaped = 1'b1;
      end else begin
        case (m)
          M_COMMENT: if (line_end(b)) m = M_INIT;
          M_SECTION: begin
            if (b == ChRBrack) begin
              finish_token(KIND_SECTION, MARK_DONE);
              m = M_INIT;
            end else begin
              body_char(b, KIND_SECTION);
            end
          end
          M_KEY: begin
            if (b == ChEquals) begin
              finish_token(KIND_KEY, MARK_DONE);
              m      = M_VALUE;
              quoted = 1'b0;
            end else if (line_end(b)) begin
              finish_token(KIND_KEY, MARK_DISCARD);
              m = M_INIT;
            end else if (b == ChSemi) begin
              finish_token(KIND_KEY, MARK_DISCARD);
              m = M_COMMENT;
            end else if (b == ChDot) begin
              emit_token_char(ChSlash, KIND_KEY);
            end else begin
              body_char(b, KIND_KEY);
            end
          end
          M_VALUE: begin
            if (b == ChQuote) quoted = !quoted;
            if (line_end(b) || (!quoted && (b == ChSemi || b == break_char))) begin
              finish_token(KIND_VALUE, MARK_DONE);
              m = (b != break_char && b == ChSemi) ? M_COMMENT : M_INIT;
            end else begin
              body_char(b, KIND_VALUE);
            end
          end
          default: begin
            if (b == ChLBrack) begin
              m = M_SECTION;
            end else if (b == ChSemi) begin
              m = M_COMMENT;
            end else if (!blank(b)) begin
              m = M_KEY;
              emit_token_char((b == ChDot) ? ChSlash : b, KIND_KEY);
            end
          end
        endcase
      end
      mode = m;
      if (due_beats.size() > first) due_beats[due_beats.size() - 1].last = 1'b1;
    endfunction

    function void compare(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        faults++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    // Match one result beat against the oldest queued beat
    function void match_beat(logic [7:0] ch, logic [4:0] user, logic lst);
      token_beat_t want;
      if (due_beats.size() == 0) begin
        faults++;
        $display("%0t: beat with nothing expected, expected none, got char %h user %h last %b",
                 $time, ch, user, lst);
        return;
      end
      want = due_beats.pop_front();
      compare("char", want.ch, ch);
      compare("kind", want.kind, user[1:0]);
      compare("mark", want.mark, user[3:2]);
      compare("overflow", want.ovf, user[4]);
      compare("last", want.last, lst);
    endfunction

    function int pending();
      return due_beats.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic [7:0] cfg_wdata  = 8'h00;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;   // [7:0] in_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;            // [7:0] out_char
  logic [4:0] out_tuser;            // [1:0] token_kind, [3:2] mark, [4] space_overflow
  logic       out_tlast;

  token_tracker tracker = new();

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int bytes_sent      = 0;
  int quiet_cycles    = 0;
  int hold_left       = 0;
  bit hold_tgl        = 1'b0;
  bit hold_seen       = 1'b0;

  ini_stream_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off whenever the toggle flips.
  // The hold-off is counted here so the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen  <= hold_tgl;
      hold_left  <= HoldOffCycles;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sample both handshakes on the edge; inputs first so that any beat caused
  // by a byte is always queued before it can be matched.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.take_byte(in_tdata);
      if (out_tvalid && out_tready) tracker.match_beat(out_tdata, out_tuser, out_tlast);
    end
  end

  // Watchdog: give up once nothing has moved on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, WatchdogLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles ahead of it; return on acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Inner whitespace: mostly short runs, now and then past the hold depth
  task automatic send_blanks(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(2))
        0:       send_byte(ChSpace);
        1:       send_byte(ChTab);
        default: send_byte(ChFf);
      endcase
    end
  endtask

  task automatic send_eol();
    case ($urandom_range(3))
      0: send_byte(ChLf);
      1: send_byte(ChCr);
      2: send_byte(ChVt);
      default: begin
        send_byte(ChCr);
        send_byte(ChLf);
      end
    endcase
  endtask

  function automatic logic [7:0] pick_text();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 8'h61 + 8'($urandom_range(25));
    if (r < 68) return 8'h30 + 8'($urandom_range(9));
    if (r < 76) return ChDot;
    if (r < 82) return ChQuote;
    if (r < 87) return ChEquals;
    if (r < 93) return tracker.break_char;
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  // Token body: text with blank runs and escaped bytes of any value
  task automatic send_body();
    int unsigned len;
    int unsigned r;
    len = $urandom_range(1, 7);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_blanks(($urandom_range(5) == 0) ? $urandom_range(15, 21) : $urandom_range(1, 3));
      end else if (r < 20) begin
        send_byte(ChBackslash);
        send_byte(8'($urandom_range(255)));
      end else begin
        send_byte(pick_text());
      end
    end
  endtask

  task automatic send_comment();
    send_byte(ChSemi);
    repeat ($urandom_range(4)) send_byte(pick_text());
    if ($urandom_range(3) == 0) begin
      send_byte(ChBackslash);
      send_byte(ChLf);
    end
    send_eol();
  endtask

  // One random line; mostly well formed so the value and key states get
  // exercised, with abandoned keys and raw noise mixed in
  task automatic random_line();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_blanks($urandom_range(2));
      send_byte(ChLBrack);
      send_blanks($urandom_range(2));
      send_body();
      send_byte(ChRBrack);
      send_eol();
    end else if (pick < 65) begin
      send_blanks($urandom_range(2));
      send_body();
      send_blanks($urandom_range(2));
      send_byte(ChEquals);
      send_blanks($urandom_range(2));
      send_body();
      case ($urandom_range(3))
        0:       send_eol();
        1:       send_comment();
        2:       send_byte(tracker.break_char);
        default: ;
      endcase
    end else if (pick < 75) begin
      send_comment();
    end else if (pick < 87) begin
      send_body();
      if ($urandom_range(1)) send_eol();
      else send_comment();
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
    end
  endtask

  // Hold the input, wait until every owed beat is out, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_break(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.break_char = v;
  endtask

  task automatic random_phase(input int idle, input int stall, input logic [7:0] brk,
                              input bit hold_off);
    int stop_at;
    drain();
    write_break(brk);
    sender_idle_pct = idle;
    recv_stall_pct  = stall;
    if (hold_off) hold_tgl <= ~hold_tgl;
    stop_at = bytes_sent + PhaseBytes;
    while (bytes_sent < stop_at) random_line();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty section, leading dot, quoted semicolon, escapes outside
    // keys and values, abandoned keys, '=' as a key start, escaped closing bracket
    send_str("[]");
    send_str(".a=");
    send_byte(ChQuote);
    send_byte(8'hFF);
    send_byte(ChSemi);
    send_byte(ChQuote);
    send_byte(ChSemi);
    send_byte(ChBackslash);
    send_byte(ChLf);
    send_byte(ChLf);
    send_str("k");
    send_byte(ChCr);
    send_byte(ChBackslash);
    send_byte(8'h00);
    send_byte(ChSemi);
    send_byte(ChVt);
    send_str("==");
    send_byte(ChVt);
    send_str("[a");
    send_byte(ChTab);
    send_byte(ChBackslash);
    send_str("]]");

    // Random phases: break character swept through its extremes
    random_phase(0, 0, 8'h3A, 1'b0);
    random_phase(50, 0, 8'h00, 1'b0);
    random_phase(0, 50, 8'hFF, 1'b0);
    random_phase(23, 23, ChSemi, 1'b0);
    // Long receiver hold-off while the sender keeps pushing
    random_phase(0, 0, 8'h23, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (tracker.pending() != 0)
      $display("%0t: %0d expected beats never arrived", $time, tracker.pending());
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
